FILE: rtl/core/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

    // Operation codes carried by a request.
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_BACK   = 2'd2;
    localparam logic [1:0] OP_POP_FRONT  = 2'd3;

    // Status codes returned with every result.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int WORD_W   = 32;
    localparam int LENGTH_W = 4;

    // One request as it enters the block.
    typedef struct packed {
        logic [1:0]               operation;
        logic signed [WORD_W-1:0] push_value;
    } request_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] pop_value;
        logic [LENGTH_W-1:0]      length;
    } result_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic              push_back;
        logic              pop_back;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/rbd_cell.sv
`timescale 1ns / 1ps

// One storage cell of the deque chain. Entries sit packed from cell 0
// (the front) upward, so each cell decides its own move from the broadcast
// command and its own and its neighbors' valid flags.
module rbd_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbd_pkg::cell_ctrl_t           ctrl,
    input  logic [rbd_pkg::WORD_W-1:0]    left_data,
    input  logic                          left_valid,
    input  logic [rbd_pkg::WORD_W-1:0]    right_data,
    input  logic                          right_valid,
    output logic [rbd_pkg::WORD_W-1:0]    data,
    output logic                          valid,
    output logic [rbd_pkg::WORD_W-1:0]    tail_tap
);

    logic [rbd_pkg::WORD_W-1:0] data_reg;
    logic [rbd_pkg::WORD_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       is_tail;
    logic                       is_free_head;

    // This cell holds the back entry, or is the first empty slot past it.
    assign is_tail      = valid_reg & ~right_valid;
    assign is_free_head = ~valid_reg & left_valid;

    // Next contents: shift toward the back, shift toward the front,
    // append at the back or drop the back entry.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift_up)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.shift_down)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.push_back && is_free_head)
        begin
            data_next  = ctrl.value;
            valid_next = 1'b1;
        end
        else if (ctrl.pop_back && is_tail)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored word needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign tail_tap = is_tail ? data_reg : '0;

endmodule

FILE: rtl/core/ring_buffer_deque.sv
`timescale 1ns / 1ps

// Double-ended queue of up to CAPACITY signed 32-bit words. Each request
// (push back, push front, pop back, pop front) is taken while
// start is high, and busy never rises, so a new request can follow every
// cycle. Its result appears on the next cycle with result_valid high for
// exactly one cycle and must be captured then; it cannot be held off. A
// push into a full deque returns the full status and a pop from an empty
// deque returns the empty status with a zero word; neither changes the
// contents. The words live in a chain of CAPACITY cells with the front
// entry always in the first cell: pushes and pops at the front shift the
// whole chain by one place, while back operations touch only the cell at
// the end of the filled run, whose word reaches the output through an OR
// of one-hot cell taps. The length field carries the low four bits of the
// entry count.
module ring_buffer_deque
#(
    parameter int CAPACITY = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rbd_pkg::request_t request,
    output logic              result_valid,
    output rbd_pkg::result_t  result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [rbd_pkg::WORD_W-1:0] cell_data [CAPACITY];
    logic [rbd_pkg::WORD_W-1:0] cell_tap  [CAPACITY];
    logic [CAPACITY-1:0]        cell_valid;
    rbd_pkg::cell_ctrl_t        ctrl;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    rbd_pkg::result_t           result_reg;
    rbd_pkg::result_t           result_next;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [rbd_pkg::WORD_W-1:0] back_word;
    logic [CNT_W+rbd_pkg::LENGTH_W-1:0] count_wide;

    assign accept = start & ~busy;
    assign full   = cell_valid[CAPACITY-1];
    assign empty  = ~cell_valid[0];

    // The chain of cells; cell 0 holds the front entry.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [rbd_pkg::WORD_W-1:0] left_data;
        logic                       left_valid;
        logic [rbd_pkg::WORD_W-1:0] right_data;
        logic                       right_valid;

        if (i == 0)
        begin : g_first
            assign left_data  = request.push_value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        rbd_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail_tap    (cell_tap[i])
        );
    end

    // Only the back cell drives a nonzero tap, so an OR picks its word.
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_word = back_word | cell_tap[i];
        end
    end

    // Decode the request into chain commands, status and new count.
    always_comb
    begin
        ctrl              = '0;
        ctrl.value        = request.push_value;
        count_next        = count_reg;
        result_next       = '0;
        result_valid_next = accept;
        case (request.operation)
            rbd_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    result_next.status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.push_back = accept;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            rbd_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    result_next.status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.shift_up = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            rbd_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    result_next.status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.pop_back         = accept;
                    result_next.pop_value = back_word;
                    count_next            = count_reg - CNT_W'(1);
                end
            end
            rbd_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    result_next.status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.shift_down       = accept;
                    result_next.pop_value = cell_data[0];
                    count_next            = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                result_next.status = rbd_pkg::ST_DONE;
            end
        endcase
        count_wide         = {{rbd_pkg::LENGTH_W{1'b0}}, count_next};
        result_next.length = count_wide[rbd_pkg::LENGTH_W-1:0];
    end

    // Entry count and result strobe are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign busy         = 1'b0;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
